// File: sv/amf_pkg.sv
// amf_pkg: shared constants, payload types and control structs of the adaptive median filter
// used by every file of the block; depends on nothing else
package amf_pkg;

  // image geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int STORED_ROWS = 4;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_DIM     = 5;
  localparam int WIDTH_RST   = 512;
  localparam int HEIGHT_RST  = 512;

  // window geometry
  localparam int WIN       = 5;
  localparam int HALF      = WIN / 2;
  localparam int TAPS      = WIN * WIN;
  localparam int CENTER    = TAPS / 2;
  localparam int MED_RANK  = TAPS / 2;
  localparam int SM_TAPS   = 9;
  localparam int SM_MED    = SM_TAPS / 2;
  localparam int SM_IDX [SM_TAPS] = '{6, 7, 8, 11, 12, 13, 16, 17, 18};

  // widths
  localparam int PIX_W     = 8;
  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WU_W      = $clog2(MAX_WIDTH + 1);
  localparam int HU_W      = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 4);
  localparam int OROW_W    = $clog2(MAX_HEIGHT);
  localparam int LAT_W     = $clog2(2 * MAX_WIDTH + 3);
  localparam int SEL_W     = $clog2(WIN);
  localparam int RANK_W    = $clog2(TAPS);
  localparam int SM_RANK_W = $clog2(SM_TAPS);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // register map
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel_in;
    logic drain;
  } in_item_t;

  typedef struct packed {
    pix_t pixel_out;
    logic last;
  } out_item_t;

  // frame geometry in use plus restart pulse
  typedef struct packed {
    logic [WU_W-1:0] width;
    logic [HU_W-1:0] height;
    logic            restart;
  } frame_cfg_t;

  // one filter job: clamped 5x5 window and its flags
  typedef struct packed {
    pix_t [TAPS-1:0] taps;
    logic            border;
    logic            last;
  } job_t;

endpackage

// File: sv/adaptive_median_filter.sv
// adaptive_median_filter: top level, register port, window front, job queue, ranking back
// depends on amf_pkg, amf_front, amf_queue, amf_back
//
//   port group   direction  payload         request taken when
//   in_          input      in_item_t       in_valid & !in_stall
//   out_         output     out_item_t      out_valid & !out_stall
//   apb (cfg)    input      width, height   psel & penable & pwrite & pready
//
// one request per cycle sustained when nothing stalls; the front pipeline (line store read,
// window) and the four-stage ranking back end run concurrently, linked by a two-entry queue
// a result leaves 2*width+2 pixel requests after its own pixel; out_valid rises once the
// request releasing it has passed the two front stages, the queue and the back end stages
// reset: rst_n synchronous, clears positions, valids and queue; line stores are not cleared
// out_stall fills the queue and then holds in_stall; drains inside a frame are taken and dropped
module adaptive_median_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  amf_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output amf_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [amf_pkg::ADDR_W-1:0] paddr,
  input  logic [amf_pkg::DATA_W-1:0] pwdata,
  output logic [amf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [amf_pkg::WREG_W-1:0] width_r;
  logic [amf_pkg::HREG_W-1:0] height_r;
  logic                       wr_en;
  amf_pkg::reg_idx_t          reg_idx;
  logic [amf_pkg::HREG_W-1:0] wx;
  amf_pkg::frame_cfg_t        cfg;
  amf_pkg::job_t              f_job, q_job;
  logic                       f_push, q_full, q_pop, q_nonempty;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = amf_pkg::reg_idx_t'(paddr[amf_pkg::ADDR_W-1]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= amf_pkg::WREG_W'(amf_pkg::WIDTH_RST);
      height_r <= amf_pkg::HREG_W'(amf_pkg::HEIGHT_RST);
    end else if (wr_en) begin
      unique case (reg_idx)
        amf_pkg::REG_WIDTH:  width_r  <= pwdata[amf_pkg::WREG_W-1:0];
        amf_pkg::REG_HEIGHT: height_r <= pwdata[amf_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      amf_pkg::REG_WIDTH:  prdata = amf_pkg::DATA_W'(width_r);
      amf_pkg::REG_HEIGHT: prdata = amf_pkg::DATA_W'(height_r);
      default:             prdata = '0;
    endcase
  end

  // saturate geometry into the usable range
  always_comb begin
    wx = amf_pkg::HREG_W'(width_r);
    if (wx < amf_pkg::HREG_W'(amf_pkg::MIN_DIM)) begin
      cfg.width = amf_pkg::WU_W'(amf_pkg::MIN_DIM);
    end else if (wx > amf_pkg::HREG_W'(amf_pkg::MAX_WIDTH)) begin
      cfg.width = amf_pkg::WU_W'(amf_pkg::MAX_WIDTH);
    end else begin
      cfg.width = amf_pkg::WU_W'(wx);
    end
    if (height_r < amf_pkg::HREG_W'(amf_pkg::MIN_DIM)) begin
      cfg.height = amf_pkg::HU_W'(amf_pkg::MIN_DIM);
    end else if (amf_pkg::HU_W'(height_r) > amf_pkg::HU_W'(amf_pkg::MAX_HEIGHT)) begin
      cfg.height = amf_pkg::HU_W'(amf_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = amf_pkg::HU_W'(height_r);
    end
    cfg.restart = wr_en;
  end

  amf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .job_push (f_push),
    .job_full (q_full),
    .job      (f_job)
  );

  amf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .din      (f_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_job)
  );

  amf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_nonempty),
    .job_pop   (q_pop),
    .job       (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: sv/amf_front.sv
// amf_front: request intake, position tracking, line stores and clamped 5x5 window build
// depends on amf_pkg
module amf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  amf_pkg::in_item_t   in_data,
  input  amf_pkg::frame_cfg_t cfg,
  output logic                job_push,
  input  logic                job_full,
  output amf_pkg::job_t       job
);

  // position counters
  logic [amf_pkg::COL_W-1:0]  ic_r, ic_nxt;
  logic [amf_pkg::ROW_W-1:0]  ir_r, ir_nxt;
  logic [amf_pkg::COL_W-1:0]  oc_r, oc_nxt;
  logic [amf_pkg::OROW_W-1:0] orow_r, orow_nxt;
  logic [amf_pkg::LAT_W-1:0]  lat_r, lat_nxt;

  // stage 1 (line store read)
  logic                         s1_v_r, s1_v_nxt;
  amf_pkg::pix_t                pix1_r;
  logic [amf_pkg::COL_W-1:0]    ic1_r;
  logic                         emit1_r, last1_r, border1_r;
  logic [amf_pkg::WIN-1:0][amf_pkg::SEL_W-1:0] rsel1_r, csel1_r;
  amf_pkg::pix_t                rd_r [amf_pkg::STORED_ROWS];

  // stage 2 (window)
  logic                         s2_v_r, s2_v_nxt;
  logic                         last2_r, border2_r;
  logic [amf_pkg::WIN-1:0][amf_pkg::SEL_W-1:0] rsel2_r, csel2_r;
  logic [amf_pkg::WIN-1:0][amf_pkg::WIN-1:0][amf_pkg::PIX_W-1:0] win_r;

  // line stores, one per stored row
  amf_pkg::pix_t lb_mem [amf_pkg::STORED_ROWS][amf_pkg::MAX_WIDTH];

  logic                      accept, take, s1_go, done, emit, frame_end;
  logic                      in_col_end, out_col_end, out_row_end, out_row_pen;
  logic                      out_col_pen, border;
  logic [amf_pkg::LAT_W-1:0] delay;
  logic [amf_pkg::WIN-1:0][amf_pkg::SEL_W-1:0] rsel, csel;
  amf_pkg::pix_t             col_in [amf_pkg::WIN];

  // handshake
  assign s1_go    = s1_v_r & (~s2_v_r | ~job_full);
  assign job_push = s2_v_r & ~job_full;
  assign in_stall = s1_v_r & ~s1_go;
  assign accept   = in_valid & ~in_stall;

  // classify the request
  assign done  = ir_r >= amf_pkg::ROW_W'(cfg.height);
  assign take  = accept & (~in_data.drain | done);
  assign delay = amf_pkg::LAT_W'({cfg.width, 1'b0}) + amf_pkg::LAT_W'(2);
  assign emit  = (lat_r == delay);

  assign in_col_end  = (amf_pkg::WU_W'(ic_r) == cfg.width - amf_pkg::WU_W'(1));
  assign out_col_end = (amf_pkg::WU_W'(oc_r) == cfg.width - amf_pkg::WU_W'(1));
  assign out_col_pen = (amf_pkg::WU_W'(oc_r) == cfg.width - amf_pkg::WU_W'(2));
  assign out_row_end = (amf_pkg::HU_W'(orow_r) == cfg.height - amf_pkg::HU_W'(1));
  assign out_row_pen = (amf_pkg::HU_W'(orow_r) == cfg.height - amf_pkg::HU_W'(2));
  assign frame_end   = emit & out_row_end & out_col_end;
  assign border      = (orow_r == '0) | (oc_r == '0) | out_row_end | out_col_end;

  // edge clamp selects for window rows and columns
  always_comb begin
    for (int k = 0; k < amf_pkg::WIN; k++) begin
      rsel[k] = amf_pkg::SEL_W'(k);
      csel[k] = amf_pkg::SEL_W'(k);
    end
    if (orow_r == '0) begin
      rsel[0] = amf_pkg::SEL_W'(amf_pkg::HALF);
      rsel[1] = amf_pkg::SEL_W'(amf_pkg::HALF);
    end else if (orow_r == amf_pkg::OROW_W'(1)) begin
      rsel[0] = amf_pkg::SEL_W'(amf_pkg::HALF - 1);
    end
    if (out_row_end) begin
      rsel[3] = amf_pkg::SEL_W'(amf_pkg::HALF);
      rsel[4] = amf_pkg::SEL_W'(amf_pkg::HALF);
    end else if (out_row_pen) begin
      rsel[4] = amf_pkg::SEL_W'(amf_pkg::HALF + 1);
    end
    if (oc_r == '0) begin
      csel[0] = amf_pkg::SEL_W'(amf_pkg::HALF);
      csel[1] = amf_pkg::SEL_W'(amf_pkg::HALF);
    end else if (oc_r == amf_pkg::COL_W'(1)) begin
      csel[0] = amf_pkg::SEL_W'(amf_pkg::HALF - 1);
    end
    if (out_col_end) begin
      csel[3] = amf_pkg::SEL_W'(amf_pkg::HALF);
      csel[4] = amf_pkg::SEL_W'(amf_pkg::HALF);
    end else if (out_col_pen) begin
      csel[4] = amf_pkg::SEL_W'(amf_pkg::HALF + 1);
    end
  end

  // position and latency counters
  always_comb begin
    ic_nxt   = ic_r;
    ir_nxt   = ir_r;
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    lat_nxt  = lat_r;
    if (cfg.restart || (take && frame_end)) begin
      ic_nxt   = '0;
      ir_nxt   = '0;
      oc_nxt   = '0;
      orow_nxt = '0;
      lat_nxt  = '0;
    end else if (take) begin
      if (in_col_end) begin
        ic_nxt = '0;
        ir_nxt = ir_r + amf_pkg::ROW_W'(1);
      end else begin
        ic_nxt = ic_r + amf_pkg::COL_W'(1);
      end
      if (emit) begin
        if (out_col_end) begin
          oc_nxt   = '0;
          orow_nxt = orow_r + amf_pkg::OROW_W'(1);
        end else begin
          oc_nxt = oc_r + amf_pkg::COL_W'(1);
        end
      end else begin
        lat_nxt = lat_r + amf_pkg::LAT_W'(1);
      end
    end
  end

  // stage valids
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_go) begin
      s2_v_nxt = emit1_r;
    end else if (job_push) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r   <= '0;
      ir_r   <= '0;
      oc_r   <= '0;
      orow_r <= '0;
      lat_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      ic_r   <= ic_nxt;
      ir_r   <= ir_nxt;
      oc_r   <= oc_nxt;
      orow_r <= orow_nxt;
      lat_r  <= lat_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // line store read and rotate-down write
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < amf_pkg::STORED_ROWS; k++) begin
        rd_r[k] <= lb_mem[k][ic_r];
      end
    end
    if (s1_go) begin
      lb_mem[0][ic1_r] <= pix1_r;
      for (int k = 1; k < amf_pkg::STORED_ROWS; k++) begin
        lb_mem[k][ic1_r] <= rd_r[k-1];
      end
    end
  end

  // new window column, oldest row first
  always_comb begin
    for (int k = 0; k < amf_pkg::STORED_ROWS; k++) begin
      col_in[k] = rd_r[amf_pkg::STORED_ROWS-1-k];
    end
    col_in[amf_pkg::WIN-1] = pix1_r;
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (take) begin
      pix1_r    <= in_data.pixel_in;
      ic1_r     <= ic_r;
      emit1_r   <= emit;
      last1_r   <= frame_end;
      border1_r <= border;
      rsel1_r   <= rsel;
      csel1_r   <= csel;
    end
    if (s1_go) begin
      for (int k = 0; k < amf_pkg::WIN; k++) begin
        for (int m = 0; m < amf_pkg::WIN-1; m++) begin
          win_r[k][m] <= win_r[k][m+1];
        end
        win_r[k][amf_pkg::WIN-1] <= col_in[k];
      end
      last2_r   <= last1_r;
      border2_r <= border1_r;
      rsel2_r   <= rsel1_r;
      csel2_r   <= csel1_r;
    end
  end

  // clamped window out to the queue
  always_comb begin
    for (int k = 0; k < amf_pkg::WIN; k++) begin
      for (int m = 0; m < amf_pkg::WIN; m++) begin
        job.taps[k*amf_pkg::WIN+m] = win_r[rsel2_r[k]][csel2_r[m]];
      end
    end
    job.border = border2_r;
    job.last   = last2_r;
  end

endmodule

// File: sv/amf_queue.sv
// amf_queue: short job queue between window build and ranking pipeline
// depends on amf_pkg
module amf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  amf_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output amf_pkg::job_t dout
);

  amf_pkg::job_t              q_mem [amf_pkg::QDEPTH];
  logic [amf_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [amf_pkg::QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == amf_pkg::QCNT_W'(amf_pkg::QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign dout     = q_mem[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + amf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + amf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + amf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - amf_pkg::QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: sv/amf_back.sv
// amf_back: rank-based min, median and max of both windows, filter decision, output register
// depends on amf_pkg
module amf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_pop,
  input  amf_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_stall,
  output amf_pkg::out_item_t out_data
);

  logic en;

  // stage 1: job
  logic                       b1_v_r;
  amf_pkg::job_t              j1_r;
  // stage 2: compare matrices
  logic                       b2_v_r;
  amf_pkg::job_t              j2_r;
  logic [amf_pkg::TAPS-1:0][amf_pkg::TAPS-1:0]       lt_r, lt_c;
  logic [amf_pkg::SM_TAPS-1:0][amf_pkg::SM_TAPS-1:0] lts_r, lts_c;
  // stage 3: ranks
  logic                       b3_v_r;
  amf_pkg::job_t              j3_r;
  logic [amf_pkg::TAPS-1:0][amf_pkg::RANK_W-1:0]       rank_r;
  logic [amf_pkg::SM_TAPS-1:0][amf_pkg::SM_RANK_W-1:0] rks_r;
  // output
  logic                       out_v_r;
  amf_pkg::out_item_t         out_data_r;

  amf_pkg::pix_t sm_pix [amf_pkg::SM_TAPS];
  amf_pkg::pix_t min5, med5, max5, min3, med3, max3, z, res;

  assign en        = ~out_v_r | ~out_stall;
  assign job_pop   = en & job_valid;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // pairwise compares, ties broken by tap index
  always_comb begin
    for (int i = 0; i < amf_pkg::SM_TAPS; i++) begin
      sm_pix[i] = j1_r.taps[amf_pkg::SM_IDX[i]];
    end
    for (int i = 0; i < amf_pkg::TAPS; i++) begin
      for (int j = 0; j < amf_pkg::TAPS; j++) begin
        lt_c[i][j] = (i != j) && ((j1_r.taps[j] < j1_r.taps[i]) ||
                     ((j1_r.taps[j] == j1_r.taps[i]) && (j < i)));
      end
    end
    for (int i = 0; i < amf_pkg::SM_TAPS; i++) begin
      for (int j = 0; j < amf_pkg::SM_TAPS; j++) begin
        lts_c[i][j] = (i != j) && ((sm_pix[j] < sm_pix[i]) ||
                      ((sm_pix[j] == sm_pix[i]) && (j < i)));
      end
    end
  end

  // pick by rank and decide
  always_comb begin
    min5 = '0;
    med5 = '0;
    max5 = '0;
    min3 = '0;
    med3 = '0;
    max3 = '0;
    for (int i = 0; i < amf_pkg::TAPS; i++) begin
      if (rank_r[i] == '0) min5 |= j3_r.taps[i];
      if (rank_r[i] == amf_pkg::RANK_W'(amf_pkg::MED_RANK)) med5 |= j3_r.taps[i];
      if (rank_r[i] == amf_pkg::RANK_W'(amf_pkg::TAPS - 1)) max5 |= j3_r.taps[i];
    end
    for (int i = 0; i < amf_pkg::SM_TAPS; i++) begin
      if (rks_r[i] == '0) min3 |= j3_r.taps[amf_pkg::SM_IDX[i]];
      if (rks_r[i] == amf_pkg::SM_RANK_W'(amf_pkg::SM_MED)) begin
        med3 |= j3_r.taps[amf_pkg::SM_IDX[i]];
      end
      if (rks_r[i] == amf_pkg::SM_RANK_W'(amf_pkg::SM_TAPS - 1)) begin
        max3 |= j3_r.taps[amf_pkg::SM_IDX[i]];
      end
    end
    z = j3_r.taps[amf_pkg::CENTER];
    if (j3_r.border) begin
      res = z;
    end else if ((min3 < med3) && (med3 < max3)) begin
      res = ((min3 < z) && (z < max3)) ? z : med3;
    end else begin
      res = ((min5 < z) && (z < max5)) ? z : med5;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r  <= job_pop;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      out_v_r <= b3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      j1_r  <= job;
      j2_r  <= j1_r;
      lt_r  <= lt_c;
      lts_r <= lts_c;
      j3_r  <= j2_r;
      for (int i = 0; i < amf_pkg::TAPS; i++) begin
        rank_r[i] <= amf_pkg::RANK_W'($countones(lt_r[i]));
      end
      for (int i = 0; i < amf_pkg::SM_TAPS; i++) begin
        rks_r[i] <= amf_pkg::SM_RANK_W'($countones(lts_r[i]));
      end
      out_data_r.pixel_out <= res;
      out_data_r.last      <= j3_r.last;
    end
  end

endmodule

// File: sv/amf_checker.sv
// amf_checker: port-level checks of the adaptive median filter, bound to the top level
// depends on amf_pkg and adaptive_median_filter
module amf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input amf_pkg::out_item_t out_data,
  input logic               pready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // nothing leaves in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // intake never blocks right after reset
  a_reset_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // register port has no wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid || !in_valid |-> pready)
    else $error("register port not ready");

endmodule

bind adaptive_median_filter amf_checker u_amf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .pready    (pready)
);
